>>> hdl/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared types, constants and helpers for the wrapping texture sampler.
// ----------------------------------------------------------------------------
package tsw_pkg;

	localparam int unsigned MAX_WIDTH   = 256;
	localparam int unsigned MAX_HEIGHT  = 256;
	localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned DIM_W       = 9;
	localparam int unsigned COORD_W     = 8;
	localparam int unsigned FRAC_W      = 16;
	localparam int unsigned WGT_W       = FRAC_W + 1;
	localparam int unsigned TEXEL_W     = 32;
	localparam int unsigned CH_W        = 8;
	localparam int unsigned NUM_CH      = TEXEL_W / CH_W;
	localparam int unsigned ACC_W       = 10;

	localparam logic [WGT_W-1:0]  ONE_Q16      = WGT_W'(1) << FRAC_W;
	localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'hFF;
	localparam logic [DIM_W-1:0]  WIDTH_MAX    = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0]  HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

	// configuration register indexes
	localparam logic [1:0] REG_TEX_WIDTH    = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_TEXEL_FORMAT = 2'd2;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;
	localparam logic FMT_BGR     = 1'b0;
	localparam logic FMT_BGRA    = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCALE = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// weight that travels with a store read
	typedef struct packed {
		logic             vld;
		logic [WGT_W-1:0] wgt;
	} tap_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] val,
			input logic [DIM_W-1:0] max_val);
		logic [DIM_W-1:0] res;
		if (val == '0) begin
			res = DIM_W'(1);
		end else if (val > max_val) begin
			res = max_val;
		end else begin
			res = val;
		end
		return res;
	endfunction

endpackage

>>> hdl/texture_sampler_wrap_bilinear.sv
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear
// Texture store with wrap addressing and nearest or bilinear sampling.
// ----------------------------------------------------------------------------
// Usage: a request is taken when req_valid is high and req_stall is low.
// A load request (mode 0) writes one texel into the 64K x 32 store in the
// accept cycle and gives no result; loads go at one per cycle while no
// sample is in work. A sample request (mode 1) gives one color on the
// result channel, taken when res_valid is high and res_stall is low.
// A sample is worked by a sequencer around the store's single read port:
// a scale state, one store read per texel (one for nearest, four for
// bilinear), a drain state and an output state. No new request is taken
// until the sample leaves its output state, so the store read port, used
// once per texel, limits the sample rate.
// A finished color sits in the output register; while the receiver stalls
// the next request is still taken, and a later sample waits in its output
// cycle until the register frees.
// Reset clears control state and sets 256 x 256 texels in BGRA format;
// store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module texture_sampler_wrap_bilinear
	import tsw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               mode,
	input  logic [15:0]        texel_index,
	input  logic [31:0]        texel_value,
	input  logic [15:0]        u_frac,
	input  logic [15:0]        v_frac,
	input  logic               bilinear,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [31:0]        color
);

	state_t              state_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic                fmt_q;
	logic [FRAC_W-1:0]   u_q;
	logic [FRAC_W-1:0]   v_q;
	logic                bil_q;
	logic [1:0]          tap_q;
	logic [COORD_W-1:0]  left_q;
	logic [COORD_W-1:0]  right_q;
	logic [COORD_W-1:0]  up_q;
	logic [COORD_W-1:0]  down_q;
	logic [FRAC_W-1:0]   du_q;
	logic [FRAC_W-1:0]   dv_q;
	logic                res_valid_q;
	logic [TEXEL_W-1:0]  color_q;

	logic                req_take;
	logic                store_we;
	logic [TEXEL_W-1:0]  store_wdata;
	logic [DIM_W-1:0]    mul_x;
	logic [DIM_W-1:0]    mul_y;
	logic [FRAC_W+DIM_W-1:0] su;
	logic [FRAC_W+DIM_W-1:0] sv;
	logic [DIM_W-1:0]    xp1;
	logic [DIM_W-1:0]    yp1;
	logic                issue;
	logic                last_tap;
	logic                out_free;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [TEXEL_W-1:0]  rd_data;
	tap_t                tap_s1;
	logic [TEXEL_W-1:0]  blend_color;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign store_we  = req_take && (mode == MODE_LOAD);
	assign store_wdata = (fmt_q == FMT_BGR) ? {ALPHA_OPAQUE, texel_value[23:0]} : texel_value;
	assign out_free  = !res_valid_q || !res_stall;
	assign issue     = (state_q == ST_FETCH);
	assign last_tap  = !bil_q || (tap_q == 2'd3);

	// nearest scales by the size, bilinear by the size minus one
	always_comb begin
		mul_x = bil_q ? width_q - DIM_W'(1) : width_q;
		mul_y = bil_q ? height_q - DIM_W'(1) : height_q;
		su    = {{DIM_W{1'b0}}, u_q} * {{FRAC_W{1'b0}}, mul_x};
		sv    = {{DIM_W{1'b0}}, v_q} * {{FRAC_W{1'b0}}, mul_y};
		xp1   = {1'b0, su[FRAC_W+COORD_W-1:FRAC_W]} + DIM_W'(1);
		yp1   = {1'b0, sv[FRAC_W+COORD_W-1:FRAC_W]} + DIM_W'(1);
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_MAX;
			height_q <= HEIGHT_MAX;
			fmt_q    <= FMT_BGRA;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEX_WIDTH:    width_q  <= clamp_dim(cfg_data, WIDTH_MAX);
				REG_TEX_HEIGHT:   height_q <= clamp_dim(cfg_data, HEIGHT_MAX);
				REG_TEXEL_FORMAT: fmt_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take && (mode == MODE_SAMPLE)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					tap_q   <= '0;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					tap_q <= tap_q + 2'd1;
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			u_q   <= u_frac;
			v_q   <= v_frac;
			bil_q <= bilinear;
		end
		if (state_q == ST_SCALE) begin
			left_q  <= su[FRAC_W+COORD_W-1:FRAC_W];
			up_q    <= sv[FRAC_W+COORD_W-1:FRAC_W];
			right_q <= (xp1 == width_q) ? '0 : xp1[COORD_W-1:0];
			down_q  <= (yp1 == height_q) ? '0 : yp1[COORD_W-1:0];
			du_q    <= bil_q ? su[FRAC_W-1:0] : '0;
			dv_q    <= bil_q ? sv[FRAC_W-1:0] : '0;
		end
		if ((state_q == ST_DONE) && out_free) begin
			color_q <= blend_color;
		end
	end

	tsw_store u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (texel_index),
		.wdata (store_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	tsw_fetch u_fetch (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.tap    (tap_q),
		.left   (left_q),
		.right  (right_q),
		.up     (up_q),
		.down   (down_q),
		.du     (du_q),
		.dv     (dv_q),
		.width  (width_q),
		.height (height_q),
		.re     (rd_en),
		.raddr  (rd_addr),
		.tap_s1 (tap_s1)
	);

	tsw_blend u_blend (
		.clk    (clk),
		.clear  (state_q == ST_SCALE),
		.tap_s1 (tap_s1),
		.rdata  (rd_data),
		.color  (blend_color)
	);

	assign res_valid = res_valid_q;
	assign color     = color_q;

endmodule

>>> hdl/tsw_store.sv
// ----------------------------------------------------------------------------
// tsw_store
// Texel store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsw_store
	import tsw_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [TEXEL_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [TEXEL_W-1:0] rdata
);

	logic [TEXEL_W-1:0] mem [STORE_DEPTH];
	logic [TEXEL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tsw_fetch.sv
// ----------------------------------------------------------------------------
// tsw_fetch
// Turns one neighbour pick into a store address and its blend weight.
// ----------------------------------------------------------------------------
module tsw_fetch
	import tsw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               issue,
	input  logic [1:0]         tap,
	input  logic [COORD_W-1:0] left,
	input  logic [COORD_W-1:0] right,
	input  logic [COORD_W-1:0] up,
	input  logic [COORD_W-1:0] down,
	input  logic [FRAC_W-1:0]  du,
	input  logic [FRAC_W-1:0]  dv,
	input  logic [DIM_W-1:0]   width,
	input  logic [DIM_W-1:0]   height,
	output logic               re,
	output logic [ADDR_W-1:0]  raddr,
	output tap_t               tap_s1
);

	logic [COORD_W-1:0]   col;
	logic [COORD_W-1:0]   row_y;
	logic [DIM_W-1:0]     row_full;
	logic [DIM_W+COORD_W-1:0] row_base;
	logic [WGT_W-1:0]     wa;
	logic [WGT_W-1:0]     wb;
	logic [2*WGT_W-1:0]   wprod;
	logic                 vld_s1;
	logic [WGT_W-1:0]     wgt_s1;

	always_comb begin
		col      = tap[0] ? right : left;
		row_y    = tap[1] ? down : up;
		// rows are stored bottom-up
		row_full = height - DIM_W'(1) - {1'b0, row_y};
		row_base = {{DIM_W{1'b0}}, row_full[COORD_W-1:0]} * {{COORD_W{1'b0}}, width};
		raddr    = row_base[ADDR_W-1:0] + {{(ADDR_W-COORD_W){1'b0}}, col};
		re       = issue;
		wa       = tap[0] ? {1'b0, du} : ONE_Q16 - {1'b0, du};
		wb       = tap[1] ? {1'b0, dv} : ONE_Q16 - {1'b0, dv};
		wprod    = wa * wb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		wgt_s1 <= wprod[FRAC_W+WGT_W-1:FRAC_W];
	end

	assign tap_s1 = '{vld: vld_s1, wgt: wgt_s1};

endmodule

>>> hdl/tsw_blend.sv
// ----------------------------------------------------------------------------
// tsw_blend
// Per-channel weighted accumulation of returned texels with saturation.
// ----------------------------------------------------------------------------
module tsw_blend
	import tsw_pkg::*;
(
	input  logic               clk,
	input  logic               clear,
	input  tap_t               tap_s1,
	input  logic [TEXEL_W-1:0] rdata,
	output logic [TEXEL_W-1:0] color
);

	logic [ACC_W-1:0]        acc_q  [NUM_CH];
	logic [CH_W+WGT_W-1:0]   prod   [NUM_CH];
	logic [ACC_W-1:0]        term   [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c] = {{WGT_W{1'b0}}, rdata[c*CH_W +: CH_W]} *
				{{CH_W{1'b0}}, tap_s1.wgt};
			term[c] = ACC_W'(prod[c][CH_W+WGT_W-1:FRAC_W]);
			color[c*CH_W +: CH_W] = (acc_q[c] > ACC_W'(ALPHA_OPAQUE)) ?
				ALPHA_OPAQUE : acc_q[c][CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (clear) begin
				acc_q[c] <= '0;
			end else if (tap_s1.vld) begin
				acc_q[c] <= acc_q[c] + term[c];
			end
		end
	end

endmodule
